@@ design/dtlv_pkg.sv @@
// Shared types and constants for the DER TLV header parser.
`timescale 1ns / 1ps
`default_nettype none

package dtlv_pkg;

    // Largest long-form length byte count accepted
    localparam int MAX_LENGTH_OCTETS = 8;
    // Septet index that counts as a tag-number overflow
    localparam int TAG_SEPTET_LIMIT  = 10;

    localparam int TAG_W     = 63;
    localparam int LEN_W     = 64;
    localparam int HSIZE_W   = 5;
    localparam int SEPCNT_W  = 4;
    localparam int LBLEFT_W  = 4;

    // Parser phase; the last three also carry the sticky error
    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_SEPTET  = 3'd1,
        PH_LEN     = 3'd2,
        PH_LONGLEN = 3'd3,
        PH_CONTENT = 3'd4,
        PH_ERR1    = 3'd5,
        PH_ERR2    = 3'd6,
        PH_ERR3    = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        KIND_IGNORED = 3'd0,
        KIND_TAG     = 3'd1,
        KIND_SEPTET  = 3'd2,
        KIND_LEN     = 3'd3,
        KIND_LONGLEN = 3'd4,
        KIND_CONTENT = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_TAG_LONG   = 2'd1,
        ERR_INDEF_LEN  = 2'd2,
        ERR_LEN_OCTETS = 2'd3
    } err_t;

    // One input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } req_t;

    // One classified byte
    typedef struct packed {
        logic [7:0]         data_out;
        kind_t              byte_kind;
        logic               header_done;
        logic [1:0]         tag_class;
        logic               is_constructed;
        logic [TAG_W-1:0]   tag_number;
        logic [LEN_W-1:0]   content_length;
        logic [HSIZE_W-1:0] header_size;
        logic               content_last;
        err_t               error_code;
    } res_t;

endpackage

`default_nettype wire

@@ design/dtlv_in_reg.sv @@
// Input register stage: holds one request until the decoder takes it.
`timescale 1ns / 1ps
`default_nettype none

module dtlv_in_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_valid,
    output logic               byte_stall,
    input  wire dtlv_pkg::req_t req_in,
    input  wire logic          advance,
    output logic               held_valid,
    output dtlv_pkg::req_t     held_req
);

    logic           valid_reg;
    logic           valid_next;
    dtlv_pkg::req_t req_reg;
    logic           load;

    // Take a new request when the slot is empty or drains this cycle
    assign byte_stall = valid_reg && !advance;
    assign load       = byte_valid && !byte_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= req_in;
        end
    end

    assign held_valid = valid_reg;
    assign held_req   = req_reg;

endmodule

`default_nettype wire

@@ design/dtlv_core.sv @@
// Parser state and per-byte classification logic.
`timescale 1ns / 1ps
`default_nettype none

module dtlv_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire dtlv_pkg::req_t req,
    output dtlv_pkg::res_t      res
);

    dtlv_pkg::phase_t                phase_reg, phase_next, phase_cur;
    logic [dtlv_pkg::TAG_W-1:0]      tag_reg, tag_next;
    logic [dtlv_pkg::SEPCNT_W-1:0]   sepcnt_reg, sepcnt_next;
    logic [dtlv_pkg::LEN_W-1:0]      lacc_reg, lacc_next;
    logic [dtlv_pkg::LBLEFT_W-1:0]   lbleft_reg, lbleft_next;
    logic [dtlv_pkg::LEN_W-1:0]      cleft_reg, cleft_next;
    logic [dtlv_pkg::HSIZE_W-1:0]    hcount_reg, hcount_next;
    logic [1:0]                      class_reg, class_next;
    logic                            cons_reg, cons_next;

    logic                            fin;
    logic [dtlv_pkg::LEN_W-1:0]      fin_len;
    logic [7:0]                      b;
    logic [dtlv_pkg::SEPCNT_W:0]     sep_inc;

    assign b       = req.data_byte;
    assign sep_inc = {1'b0, sepcnt_reg} + 5'd1;

    // Classify the byte and compute the next state
    always_comb
    begin
        phase_next  = phase_reg;
        tag_next    = tag_reg;
        sepcnt_next = sepcnt_reg;
        lacc_next   = lacc_reg;
        lbleft_next = lbleft_reg;
        cleft_next  = cleft_reg;
        hcount_next = hcount_reg;
        class_next  = class_reg;
        cons_next   = cons_reg;
        fin         = 1'b0;
        fin_len     = '0;
        res         = '0;
        res.data_out = b;

        // A frame start forces the byte to be a tag byte
        phase_cur = req.frame_start ? dtlv_pkg::PH_TAG : phase_reg;

        case (phase_cur)
            dtlv_pkg::PH_TAG:
            begin
                res.byte_kind = dtlv_pkg::KIND_TAG;
                class_next    = b[7:6];
                cons_next     = b[5];
                hcount_next   = 5'd1;
                sepcnt_next   = '0;
                if (b[4:0] == 5'h1F)
                begin
                    tag_next   = '0;
                    phase_next = dtlv_pkg::PH_SEPTET;
                end
                else
                begin
                    tag_next   = {{(dtlv_pkg::TAG_W-5){1'b0}}, b[4:0]};
                    phase_next = dtlv_pkg::PH_LEN;
                end
            end
            dtlv_pkg::PH_SEPTET:
            begin
                res.byte_kind = dtlv_pkg::KIND_SEPTET;
                if (sep_inc >= 5'(dtlv_pkg::TAG_SEPTET_LIMIT))
                begin
                    phase_next = dtlv_pkg::PH_ERR1;
                end
                else
                begin
                    sepcnt_next = sep_inc[dtlv_pkg::SEPCNT_W-1:0];
                    hcount_next = hcount_reg + 5'd1;
                    tag_next    = {tag_reg[dtlv_pkg::TAG_W-8:0], b[6:0]};
                    if (!b[7])
                    begin
                        phase_next = dtlv_pkg::PH_LEN;
                    end
                end
            end
            dtlv_pkg::PH_LEN:
            begin
                res.byte_kind = dtlv_pkg::KIND_LEN;
                if (!b[7])
                begin
                    hcount_next = hcount_reg + 5'd1;
                    fin         = 1'b1;
                    fin_len     = {{(dtlv_pkg::LEN_W-8){1'b0}}, b};
                end
                else if (b[6:0] == 7'd0)
                begin
                    phase_next = dtlv_pkg::PH_ERR2;
                end
                else if (b[6:0] > 7'(dtlv_pkg::MAX_LENGTH_OCTETS))
                begin
                    phase_next = dtlv_pkg::PH_ERR3;
                end
                else
                begin
                    hcount_next = hcount_reg + 5'd1;
                    lbleft_next = b[dtlv_pkg::LBLEFT_W-1:0];
                    lacc_next   = '0;
                    phase_next  = dtlv_pkg::PH_LONGLEN;
                end
            end
            dtlv_pkg::PH_LONGLEN:
            begin
                res.byte_kind = dtlv_pkg::KIND_LONGLEN;
                hcount_next   = hcount_reg + 5'd1;
                lacc_next     = {lacc_reg[dtlv_pkg::LEN_W-9:0], b};
                lbleft_next   = (lbleft_reg != '0) ? lbleft_reg - 4'd1 : lbleft_reg;
                if (lbleft_next == '0)
                begin
                    fin     = 1'b1;
                    fin_len = lacc_next;
                end
            end
            dtlv_pkg::PH_CONTENT:
            begin
                res.byte_kind = dtlv_pkg::KIND_CONTENT;
                if (cleft_reg <= 64'd1)
                begin
                    res.content_last = 1'b1;
                    cleft_next       = '0;
                    phase_next       = dtlv_pkg::PH_TAG;
                end
                else
                begin
                    cleft_next = cleft_reg - 64'd1;
                end
            end
            default:
            begin
                res.byte_kind = dtlv_pkg::KIND_IGNORED;
            end
        endcase

        // Close the header: report it and pick content or next tag
        if (fin)
        begin
            res.header_done    = 1'b1;
            res.tag_number     = tag_reg;
            res.content_length = fin_len;
            res.header_size    = hcount_next;
            if (cons_reg || (fin_len == '0))
            begin
                phase_next = dtlv_pkg::PH_TAG;
                cleft_next = '0;
            end
            else
            begin
                phase_next = dtlv_pkg::PH_CONTENT;
                cleft_next = fin_len;
            end
        end

        if (res.byte_kind != dtlv_pkg::KIND_IGNORED)
        begin
            res.tag_class      = class_next;
            res.is_constructed = cons_next;
        end

        // Report the sticky error left after this byte
        case (phase_next)
            dtlv_pkg::PH_ERR1: res.error_code = dtlv_pkg::ERR_TAG_LONG;
            dtlv_pkg::PH_ERR2: res.error_code = dtlv_pkg::ERR_INDEF_LEN;
            dtlv_pkg::PH_ERR3: res.error_code = dtlv_pkg::ERR_LEN_OCTETS;
            default:           res.error_code = dtlv_pkg::ERR_NONE;
        endcase
    end

    // Advance parser state once per decoded request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dtlv_pkg::PH_TAG;
            tag_reg    <= '0;
            sepcnt_reg <= '0;
            lacc_reg   <= '0;
            lbleft_reg <= '0;
            cleft_reg  <= '0;
            hcount_reg <= '0;
            class_reg  <= '0;
            cons_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            tag_reg    <= tag_next;
            sepcnt_reg <= sepcnt_next;
            lacc_reg   <= lacc_next;
            lbleft_reg <= lbleft_next;
            cleft_reg  <= cleft_next;
            hcount_reg <= hcount_next;
            class_reg  <= class_next;
            cons_reg   <= cons_next;
        end
    end

endmodule

`default_nettype wire

@@ design/dtlv_out_reg.sv @@
// Result register: holds one classified byte until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module dtlv_out_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           held_valid,
    input  wire dtlv_pkg::res_t res_in,
    output logic                advance,
    output logic                result_valid,
    input  wire logic           result_stall,
    output dtlv_pkg::res_t      res_out
);

    logic           valid_reg;
    logic           valid_next;
    dtlv_pkg::res_t res_reg;

    // Move a request forward when the result slot is free or being taken
    assign advance = held_valid && (!valid_reg || !result_stall);

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_in;
        end
    end

    assign result_valid = valid_reg;
    assign res_out      = res_reg;

endmodule

`default_nettype wire

@@ design/der_tlv_header_parser_unit.sv @@
// Top level of the DER TLV header parser: input register, decoder, result register.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+--------------------------------------------
//  byte    | byte_valid   | byte_stall   | data_byte, frame_start
//  result  | result_valid | result_stall | data_out, byte_kind, header_done, tag_class,
//          |              |              | is_constructed, tag_number, content_length,
//          |              |              | header_size, content_last, error_code
//
// One byte per clock sustained while result_stall is low; an accepted request is held in the
// input register, then in the result register that drives the result port. The decoder state
// updates as a request moves into the result register.
// rst_n clears the parser to expect a tag byte and empties both registers.
// result_stall holds the result register and, once both registers are full,
// raises byte_stall in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module der_tlv_header_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_start,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [7:0]       data_out,
    output logic [2:0]       byte_kind,
    output logic             header_done,
    output logic [1:0]       tag_class,
    output logic             is_constructed,
    output logic [62:0]      tag_number,
    output logic [63:0]      content_length,
    output logic [4:0]       header_size,
    output logic             content_last,
    output logic [1:0]       error_code
);

    dtlv_pkg::req_t req_in;
    dtlv_pkg::req_t held_req;
    dtlv_pkg::res_t core_res;
    dtlv_pkg::res_t res_out;
    logic           held_valid;
    logic           advance;

    assign req_in.data_byte   = data_byte;
    assign req_in.frame_start = frame_start;

    dtlv_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .req_in     (req_in),
        .advance    (advance),
        .held_valid (held_valid),
        .held_req   (held_req)
    );

    dtlv_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (held_req),
        .res     (core_res)
    );

    dtlv_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .held_valid   (held_valid),
        .res_in       (core_res),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .res_out      (res_out)
    );

    // Unpack the result register onto the ports
    assign data_out       = res_out.data_out;
    assign byte_kind      = res_out.byte_kind;
    assign header_done    = res_out.header_done;
    assign tag_class      = res_out.tag_class;
    assign is_constructed = res_out.is_constructed;
    assign tag_number     = res_out.tag_number;
    assign content_length = res_out.content_length;
    assign header_size    = res_out.header_size;
    assign content_last   = res_out.content_last;
    assign error_code     = res_out.error_code;

endmodule

`default_nettype wire

@@ design/dtlv_checker.sv @@
// Port-level checks for the DER TLV header parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dtlv_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic [7:0]  data_out,
    input wire logic [2:0]  byte_kind,
    input wire logic        header_done,
    input wire logic [4:0]  header_size,
    input wire logic        content_last,
    input wire logic [1:0]  error_code
);

    // A stalled result holds its byte and kind
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(data_out)
            && $stable(byte_kind))
    else $error("stalled result changed");

    // Only a length byte can close a header, and a header spans at least two bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && header_done |->
            (byte_kind == dtlv_pkg::KIND_LEN || byte_kind == dtlv_pkg::KIND_LONGLEN)
            && header_size >= 5'd2)
    else $error("header_done on a non-length byte");

    // The last content flag belongs to content bytes only
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && content_last |-> byte_kind == dtlv_pkg::KIND_CONTENT)
    else $error("content_last outside content");

    // An ignored byte is only shown while an error is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && byte_kind == dtlv_pkg::KIND_IGNORED |->
            error_code != dtlv_pkg::ERR_NONE)
    else $error("ignored byte without error");

endmodule

bind der_tlv_header_parser_unit dtlv_checker u_dtlv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .data_out     (data_out),
    .byte_kind    (byte_kind),
    .header_done  (header_done),
    .header_size  (header_size),
    .content_last (content_last),
    .error_code   (error_code)
);

`default_nettype wire
